/* design/sfsw_pkg.sv */
// Shared constants, payload types and helpers for the scale frame stability block.
package sfsw_pkg;

    // Frame layout
    localparam int FRAME_BYTES  = 12;
    localparam int HELD_BYTES   = FRAME_BYTES - 1;
    localparam int DIGIT_FIRST  = 2;
    localparam int DIGIT_COUNT  = 6;
    localparam int FILL_W       = $clog2(HELD_BYTES + 1);

    localparam logic [7:0] STX_CODE   = 8'h02;
    localparam logic [7:0] PROTO_CODE = 8'h2B;
    localparam logic [7:0] ETX_CODE   = 8'h03;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;

    // Output widths
    localparam int WEIGHT_W = 20;
    localparam int COUNT_W  = 4;
    localparam int PART_W   = 10;

    // Configuration register map
    localparam int                 ADDR_W          = 3;
    localparam logic               REG_THRESHOLD   = 1'b0;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 4'd3;

    // Frame queue depth between the front and back ends
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_value;
        logic                digits_bad;
        logic                stable_hit;
        logic [COUNT_W-1:0]  repeat_count;
    } out_word_t;

    // One matched frame: decimal digits, most significant first, zeroed when bad
    typedef struct packed {
        logic [DIGIT_COUNT-1:0][3:0] digits;
        logic                        bad;
    } frame_rec_t;

    // True when a byte is an ASCII decimal digit.
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= DIGIT_LO) && (c <= DIGIT_HI);
    endfunction

    // Value of three decimal digits, most significant first.
    function automatic logic [PART_W-1:0] three_digits(input logic [3:0] d2,
                                                       input logic [3:0] d1,
                                                       input logic [3:0] d0);
        return PART_W'(d2) * PART_W'(100) + PART_W'(d1) * PART_W'(10) + PART_W'(d0);
    endfunction

endpackage

/* design/sfsw_stream_if.sv */
// Valid/ready stream channel carrying one word of a given payload type.
interface sfsw_stream_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/sfsw_front.sv */
// Front end: byte window, frame match and digit classification.
module sfsw_front (
    input  logic          clk,
    input  logic          rst_n,
    sfsw_stream_if.sink   rx,
    sfsw_stream_if.source frame
);

    logic [7:0]                    window_reg [sfsw_pkg::HELD_BYTES];
    logic [sfsw_pkg::FILL_W-1:0]   fill_reg;
    logic [sfsw_pkg::FILL_W-1:0]   fill_next;
    logic                          match;
    logic                          accept;
    logic                          all_ok;
    sfsw_pkg::frame_rec_t          rec;

    // A frame ends here when the full window starts with STX and the protocol byte.
    assign match = (fill_reg == sfsw_pkg::FILL_W'(sfsw_pkg::HELD_BYTES))
                && (window_reg[0] == sfsw_pkg::STX_CODE)
                && (window_reg[1] == sfsw_pkg::PROTO_CODE)
                && (rx.payload.rx_byte == sfsw_pkg::ETX_CODE);

    // Classify the six weight digits of the window.
    always_comb
    begin
        all_ok = 1'b1;
        for (int i = 0; i < sfsw_pkg::DIGIT_COUNT; i++)
        begin
            all_ok = all_ok && sfsw_pkg::is_digit(window_reg[sfsw_pkg::DIGIT_FIRST + i]);
        end
        for (int i = 0; i < sfsw_pkg::DIGIT_COUNT; i++)
        begin
            rec.digits[sfsw_pkg::DIGIT_COUNT-1-i] =
                all_ok ? window_reg[sfsw_pkg::DIGIT_FIRST + i][3:0] : 4'd0;
        end
        rec.bad = !all_ok;
    end

    // A byte is taken whenever the queue has room for a possible frame.
    assign rx.ready      = frame.ready;
    assign accept        = rx.valid && rx.ready;
    assign frame.valid   = rx.valid && match;
    assign frame.payload = rec;

    // Fill count restarts after a match and saturates at a full window.
    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            if (match)
            begin
                fill_next = '0;
            end
            else if (fill_reg != sfsw_pkg::FILL_W'(sfsw_pkg::HELD_BYTES))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Window shifts toward index zero; the newest byte enters at the top.
    always_ff @(posedge clk)
    begin
        if (accept && !match)
        begin
            for (int i = 0; i < sfsw_pkg::HELD_BYTES - 1; i++)
            begin
                window_reg[i] <= window_reg[i + 1];
            end
            window_reg[sfsw_pkg::HELD_BYTES - 1] <= rx.payload.rx_byte;
        end
    end

    // The window restarts empty after every matched frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && match |=> fill_reg == '0)
        else $error("window not emptied after a frame");

endmodule

/* design/sfsw_queue.sv */
// Short frame queue that decouples the front end from the back end.
module sfsw_queue #(
    parameter int DEPTH = sfsw_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    sfsw_stream_if.sink   wr,
    sfsw_stream_if.source rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfsw_pkg::frame_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 push;
    logic                 pop;

    assign wr.ready   = (count_reg != CNT_W'(DEPTH));
    assign rd.valid   = (count_reg != '0);
    assign rd.payload = entry_reg[rd_ptr_reg];
    assign push       = wr.valid && wr.ready;
    assign pop        = rd.valid && rd.ready;

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr.payload;
        end
    end

    // Occupancy never goes past the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("frame queue overflow");

endmodule

/* design/sfsw_back.sv */
// Back end: digit to binary conversion, stability tracking and result register.
module sfsw_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sfsw_pkg::COUNT_W-1:0]  threshold,
    sfsw_stream_if.sink                   frame,
    sfsw_stream_if.source                 res
);

    // Conversion stage
    logic                              a_valid_reg;
    logic [sfsw_pkg::PART_W-1:0]       hi_reg;
    logic [sfsw_pkg::PART_W-1:0]       lo_reg;
    logic                              bad_reg;

    // Stability state
    logic [sfsw_pkg::WEIGHT_W-1:0]     last_weight_reg;
    logic                              have_last_reg;
    logic [sfsw_pkg::COUNT_W-1:0]      count_reg;

    // Result register
    logic                              out_valid_reg;
    sfsw_pkg::out_word_t               out_reg;

    logic                              out_free;
    logic                              a_move;
    logic                              a_take;
    logic [sfsw_pkg::WEIGHT_W-1:0]     weight;
    logic                              same;
    logic [sfsw_pkg::COUNT_W-1:0]      count_inc;
    logic                              stable;
    logic [sfsw_pkg::COUNT_W-1:0]      count_next;

    assign out_free    = !out_valid_reg || res.ready;
    assign a_move      = a_valid_reg && out_free;
    assign a_take      = !a_valid_reg || out_free;
    assign frame.ready = a_take;
    assign res.valid   = out_valid_reg;
    assign res.payload = out_reg;

    // Combine the two three-digit halves and check against the stored reading.
    always_comb
    begin
        weight    = sfsw_pkg::WEIGHT_W'(hi_reg) * sfsw_pkg::WEIGHT_W'(1000)
                  + sfsw_pkg::WEIGHT_W'(lo_reg);
        same      = have_last_reg && (weight == last_weight_reg);
        count_inc = count_reg + 1'b1;
        stable    = same && (count_inc >= threshold);
        if (!same || stable)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_inc;
        end
    end

    // Control state of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            have_last_reg   <= 1'b0;
            last_weight_reg <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (a_take)
            begin
                a_valid_reg <= frame.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= a_valid_reg;
            end
            if (a_move)
            begin
                count_reg <= count_next;
                if (!same)
                begin
                    last_weight_reg <= weight;
                    have_last_reg   <= 1'b1;
                end
            end
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        if (a_take && frame.valid)
        begin
            hi_reg  <= sfsw_pkg::three_digits(frame.payload.digits[5],
                                              frame.payload.digits[4],
                                              frame.payload.digits[3]);
            lo_reg  <= sfsw_pkg::three_digits(frame.payload.digits[2],
                                              frame.payload.digits[1],
                                              frame.payload.digits[0]);
            bad_reg <= frame.payload.bad;
        end
        if (a_move)
        begin
            out_reg.weight_value <= weight;
            out_reg.digits_bad   <= bad_reg;
            out_reg.stable_hit   <= stable;
            out_reg.repeat_count <= count_next;
        end
    end

    // A stable report always leaves the count cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.payload.stable_hit |-> res.payload.repeat_count == '0)
        else $error("stable result with nonzero count");

    // The count is cleared at the threshold, so it never reaches its top value.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '1)
        else $error("repeat count reached its top value");

    // A bad frame always reads as zero weight.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.payload.digits_bad |-> res.payload.weight_value == '0)
        else $error("bad frame with nonzero weight");

endmodule

/* design/scale_frame_stable_weight.sv */
// Top level: APB threshold register, front end, frame queue and back end.
//
// Usage: rx is a valid/ready byte stream from the indicator's serial receiver;
// each accepted word is one received byte. res is a valid/ready stream with
// one word per matched frame (STX, 0x2B, six ASCII digits, ..., ETX over
// twelve bytes), holding the weight, the bad-digit flag, the stable flag and
// the repeat count. Bytes that do not complete a frame give no word.
// Throughput: one byte per cycle while the queue has room. The front end
// matches the frame and pushes it into a two-entry queue in the cycle the
// closing byte is taken; the back end converts it and checks stability in
// its conversion stage and result register. The stable threshold is written
// over the APB port at address 0 (reset value 3); the user must write it only
// while the block is idle, which the block does not enforce. When res stalls,
// the result register holds and the back end stops; frames collect in the
// queue, and rx drops ready only while it is full. Reset empties the window,
// the queue and both stages, and clears the stored reading and repeat count.
module scale_frame_stable_weight #(
    parameter int QUEUE_DEPTH = sfsw_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfsw_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    sfsw_stream_if.sink                  rx,
    sfsw_stream_if.source                res
);

    logic [sfsw_pkg::COUNT_W-1:0] threshold_reg;
    logic                         wr_en;

    sfsw_stream_if #(.payload_t(sfsw_pkg::frame_rec_t)) front_q ();
    sfsw_stream_if #(.payload_t(sfsw_pkg::frame_rec_t)) q_back ();

    // Register interface: single threshold register, zero wait states.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == sfsw_pkg::REG_THRESHOLD);
    assign prdata = (paddr[2] == sfsw_pkg::REG_THRESHOLD) ? 32'(threshold_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= sfsw_pkg::THRESHOLD_RESET;
        end
        else if (wr_en)
        begin
            threshold_reg <= pwdata[sfsw_pkg::COUNT_W-1:0];
        end
    end

    sfsw_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .frame (front_q.source)
    );

    sfsw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (front_q.sink),
        .rd    (q_back.source)
    );

    sfsw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold_reg),
        .frame     (q_back.sink),
        .res       (res)
    );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the scale frame parser and stability check.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_WEIGHT    = 999999;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_AFTER    = 10;
    localparam int unsigned HOLD_CYCLES   = 120;

    // Tracks the frame window and the stored reading, and keeps the readings still owed.
    class reading_tracker;
        logic [7:0]                    held [sfsw_pkg::HELD_BYTES];
        int unsigned                   fill;
        logic [sfsw_pkg::WEIGHT_W-1:0] stored_weight;
        bit                            have_stored;
        logic [sfsw_pkg::COUNT_W-1:0]  repeats;
        logic [sfsw_pkg::COUNT_W-1:0]  threshold;
        sfsw_pkg::out_word_t           expected_readings [$];
        int unsigned                   errors;
        int unsigned                   readings_checked;
        int unsigned                   stable_seen;
        int unsigned                   bad_seen;

        function new();
            for (int i = 0; i < sfsw_pkg::HELD_BYTES; i++)
                held[i] = '0;
            fill = 0;
            stored_weight = '0;
            have_stored = 0;
            repeats = '0;
            threshold = sfsw_pkg::THRESHOLD_RESET;
            errors = 0;
            readings_checked = 0;
            stable_seen = 0;
            bad_seen = 0;
        endfunction

        function void set_threshold(input logic [sfsw_pkg::COUNT_W-1:0] value);
            threshold = value;
        endfunction

        function int unsigned pending();
            return expected_readings.size();
        endfunction

        // Feed one accepted byte; a closing byte of a matched frame yields one reading.
        function void note_byte(input logic [7:0] b);
            sfsw_pkg::out_word_t           reading;
            logic [sfsw_pkg::WEIGHT_W-1:0] value;
            bit                            bad;
            bit                            stable;
            if (fill == sfsw_pkg::HELD_BYTES && held[0] == sfsw_pkg::STX_CODE &&
                held[1] == sfsw_pkg::PROTO_CODE && b == sfsw_pkg::ETX_CODE)
            begin
                value = '0;
                bad = 0;
                for (int i = sfsw_pkg::DIGIT_FIRST;
                     i < sfsw_pkg::DIGIT_FIRST + sfsw_pkg::DIGIT_COUNT; i++)
                begin
                    if (held[i] < sfsw_pkg::DIGIT_LO || held[i] > sfsw_pkg::DIGIT_HI)
                        bad = 1;
                    else
                        value = sfsw_pkg::WEIGHT_W'(value * 10 + (held[i] - sfsw_pkg::DIGIT_LO));
                end
                if (bad)
                    value = '0;
                stable = 0;
                if (have_stored && value == stored_weight)
                begin
                    repeats = repeats + 1'b1;
                    if (repeats >= threshold)
                    begin
                        stable = 1;
                        repeats = '0;
                    end
                end
                else
                begin
                    repeats = '0;
                    stored_weight = value;
                    have_stored = 1;
                end
                // The window empties so no byte of this frame is reused.
                fill = 0;
                for (int i = 0; i < sfsw_pkg::HELD_BYTES; i++)
                    held[i] = '0;
                reading.weight_value = value;
                reading.digits_bad = bad;
                reading.stable_hit = stable;
                reading.repeat_count = repeats;
                expected_readings.push_back(reading);
            end
            else
            begin
                for (int i = 0; i < sfsw_pkg::HELD_BYTES - 1; i++)
                    held[i] = held[i + 1];
                held[sfsw_pkg::HELD_BYTES - 1] = b;
                if (fill < sfsw_pkg::HELD_BYTES)
                    fill++;
            end
        endfunction

        // Compare one result word against the oldest reading owed.
        function void check_reading(input sfsw_pkg::out_word_t got);
            sfsw_pkg::out_word_t want;
            if (expected_readings.size() == 0)
            begin
                $error("unexpected result word: weight_value %0d", got.weight_value);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            readings_checked++;
            if (want.stable_hit)
                stable_seen++;
            if (want.digits_bad)
                bad_seen++;
            if (got.weight_value !== want.weight_value)
            begin
                $error("weight_value: expected %0d, actual %0d",
                       want.weight_value, got.weight_value);
                errors++;
            end
            if (got.digits_bad !== want.digits_bad)
            begin
                $error("digits_bad: expected %0d, actual %0d", want.digits_bad, got.digits_bad);
                errors++;
            end
            if (got.stable_hit !== want.stable_hit)
            begin
                $error("stable_hit: expected %0d, actual %0d", want.stable_hit, got.stable_hit);
                errors++;
            end
            if (got.repeat_count !== want.repeat_count)
            begin
                $error("repeat_count: expected %0d, actual %0d",
                       want.repeat_count, got.repeat_count);
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [sfsw_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    sfsw_stream_if #(.payload_t(sfsw_pkg::in_word_t))  byte_ch ();
    sfsw_stream_if #(.payload_t(sfsw_pkg::out_word_t)) reading_ch ();

    scale_frame_stable_weight dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rx      (byte_ch),
        .res     (reading_ch)
    );

    reading_tracker tracker = new();
    int unsigned    bytes_sent = 0;
    int unsigned    weight_now = 0;
    logic [7:0]     frame_buf [sfsw_pkg::FRAME_BYTES];
    logic [sfsw_pkg::COUNT_W-1:0] mid_threshold;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Send one byte: random gaps, then hold the word until it is taken.
    task automatic send_byte(input logic [7:0] b);
        while (!(bytes_sent >= 250 && bytes_sent < 330) && $urandom_range(99) < 36)
        begin
            byte_ch.valid = 1'b0;
            @(negedge clk);
        end
        byte_ch.valid = 1'b1;
        byte_ch.payload = b;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        tracker.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Lay out a well-formed frame for a weight; the three bytes after the digits are random.
    task automatic build_frame(input int unsigned value);
        int unsigned divisor;
        divisor = 100000;
        frame_buf[0] = sfsw_pkg::STX_CODE;
        frame_buf[1] = sfsw_pkg::PROTO_CODE;
        for (int i = 0; i < sfsw_pkg::DIGIT_COUNT; i++)
        begin
            frame_buf[sfsw_pkg::DIGIT_FIRST + i] =
                sfsw_pkg::DIGIT_LO + 8'((value / divisor) % 10);
            divisor = divisor / 10;
        end
        for (int i = sfsw_pkg::DIGIT_FIRST + sfsw_pkg::DIGIT_COUNT;
             i < sfsw_pkg::FRAME_BYTES - 1; i++)
            frame_buf[i] = 8'($urandom_range(0, 255));
        frame_buf[sfsw_pkg::FRAME_BYTES - 1] = sfsw_pkg::ETX_CODE;
    endtask

    task automatic send_frame_bytes(input int unsigned count);
        for (int i = 0; i < count; i++)
            send_byte(frame_buf[i]);
    endtask

    // Read the threshold register over APB.
    task automatic reg_read(output logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b0;
        penable = 1'b0;
        paddr = sfsw_pkg::ADDR_W'(sfsw_pkg::REG_THRESHOLD) << 2;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        value = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Write the threshold, read it back and update the predictor.
    task automatic write_threshold(input logic [sfsw_pkg::COUNT_W-1:0] value);
        logic [31:0] readback;
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = sfsw_pkg::ADDR_W'(sfsw_pkg::REG_THRESHOLD) << 2;
        pwdata = 32'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        tracker.set_threshold(value);
        reg_read(readback);
        if (readback !== 32'(value))
        begin
            $error("stable_threshold: expected %0d, actual %0d", value, readback);
            tracker.errors++;
        end
    endtask

    // Stop offering bytes and wait until every reading owed has come back.
    task automatic wait_idle();
        byte_ch.valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly frames of a sticky weight, with noise bytes and broken frames mixed in.
    task automatic run_phase(input int unsigned budget, input int unsigned repeat_pct);
        int unsigned first;
        int unsigned pick;
        int unsigned choice;
        logic [7:0]  c;
        first = bytes_sent;
        while (bytes_sent - first < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                if ($urandom_range(99) >= repeat_pct)
                begin
                    choice = $urandom_range(7);
                    if (choice == 0)
                        weight_now = 0;
                    else if (choice == 1)
                        weight_now = MAX_WEIGHT;
                    else
                        weight_now = $urandom_range(0, MAX_WEIGHT);
                end
                build_frame(weight_now);
                if (pick < 16)
                begin
                    // Broken frame: wrong second byte, wrong closing byte, or cut short.
                    choice = $urandom_range(2);
                    if (choice == 0)
                        frame_buf[1] = 8'($urandom_range(0, 255));
                    else if (choice == 1)
                        frame_buf[sfsw_pkg::FRAME_BYTES - 1] = 8'($urandom_range(0, 255));
                    if (choice == 2)
                        send_frame_bytes($urandom_range(1, sfsw_pkg::FRAME_BYTES - 1));
                    else
                        send_frame_bytes(sfsw_pkg::FRAME_BYTES);
                end
                else
                begin
                    if ($urandom_range(99) < 8)
                    begin
                        do
                            c = 8'($urandom_range(0, 255));
                        while (c >= sfsw_pkg::DIGIT_LO && c <= sfsw_pkg::DIGIT_HI);
                        frame_buf[$urandom_range(sfsw_pkg::DIGIT_FIRST,
                            sfsw_pkg::DIGIT_FIRST + sfsw_pkg::DIGIT_COUNT - 1)] = c;
                    end
                    send_frame_bytes(sfsw_pkg::FRAME_BYTES);
                end
            end
        end
    endtask

    // Result side: random stalls, one long hold-off, and a stretch with no stalls.
    initial
    begin : result_side
        int unsigned got;
        bit          held_off;
        got = 0;
        held_off = 0;
        reading_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && got >= HOLD_AFTER)
            begin
                held_off = 1;
                reading_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            reading_ch.ready = (got >= 20 && got < 28) || ($urandom_range(99) >= 36);
            @(posedge clk);
            if (reading_ch.valid && reading_ch.ready)
            begin
                tracker.check_reading(reading_ch.payload);
                got++;
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        logic [31:0] readback;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        byte_ch.valid = 1'b0;
        byte_ch.payload = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        reg_read(readback);
        if (readback !== 32'(sfsw_pkg::THRESHOLD_RESET))
        begin
            $error("stable_threshold: expected %0d, actual %0d",
                   sfsw_pkg::THRESHOLD_RESET, readback);
            tracker.errors++;
        end

        // Directed: byte extremes, an all-zero frame, then a frame with digits just
        // outside the ASCII range on both sides, which must count as a repeat of zero.
        send_byte(8'h00);
        send_byte(8'hFF);
        build_frame(0);
        send_frame_bytes(sfsw_pkg::FRAME_BYTES);
        build_frame(0);
        frame_buf[sfsw_pkg::DIGIT_FIRST] = sfsw_pkg::DIGIT_LO - 8'd1;
        frame_buf[sfsw_pkg::DIGIT_FIRST + sfsw_pkg::DIGIT_COUNT - 1] =
            sfsw_pkg::DIGIT_HI + 8'd1;
        send_frame_bytes(sfsw_pkg::FRAME_BYTES);

        // Random phases across thresholds, the extremes among them.
        run_phase(100, 70);
        wait_idle();
        write_threshold(4'd1);
        run_phase(100, 60);
        wait_idle();
        write_threshold(4'd15);
        run_phase(200, 95);
        wait_idle();
        mid_threshold = sfsw_pkg::COUNT_W'($urandom_range(2, 14));
        write_threshold(mid_threshold);
        run_phase(100, 75);
        wait_idle();

        $display("Sent %0d bytes; checked %0d readings, %0d stable and %0d with bad digits.",
                 bytes_sent, tracker.readings_checked, tracker.stable_seen, tracker.bad_seen);
        $display("Thresholds 3, 1, 15 and %0d were used, with a %0d-cycle result hold-off.",
                 mid_threshold, HOLD_CYCLES);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
